[src/nalepb_pkg.sv]
// shared types, constants and the per-byte classification functions
`timescale 1ns / 1ps

package nalepb_pkg;

    localparam logic [7:0] EPB_BYTE    = 8'h03;
    localparam logic [7:0] START_BYTE  = 8'h01;
    localparam logic [1:0] MAX_HELD    = 2'd3;
    localparam logic [2:0] MAX_RESULTS = 3'd4;

    // one result item, nal_kind is derived from value at the output
    typedef struct packed {
        logic [7:0] value;
        logic       hdr;
        logic       last;
    } res_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [2:0]       cnt;
        res_t [3:0]       res;
    } bundle_t;

    typedef struct packed {
        logic [1:0] held_zero_count;
        logic [7:0] pending_byte;
        logic       pending_valid;
        logic       pending_is_header;
        logic       inside_nal;
        logic       next_is_header;
        logic [1:0] payload_zero_run;
    } fe_state_t;

    typedef struct packed {
        fe_state_t st;
        bundle_t   bun;
    } work_t;

    typedef struct packed {
        logic full;
        logic avail;
    } q_stat_t;

    function automatic work_t put_result(work_t w, logic [7:0] b, logic hdr, logic last);
        work_t r;
        r = w;
        if (r.bun.cnt < MAX_RESULTS)
        begin
            r.bun.res[r.bun.cnt[1:0]].value = b;
            r.bun.res[r.bun.cnt[1:0]].hdr   = hdr;
            r.bun.res[r.bun.cnt[1:0]].last  = last;
            r.bun.cnt = r.bun.cnt + 3'd1;
        end
        return r;
    endfunction

    function automatic work_t send_payload(work_t w, logic [7:0] b, logic hdr);
        work_t r;
        r = w;
        if (r.st.pending_valid)
        begin
            r = put_result(r, r.st.pending_byte, r.st.pending_is_header, 1'b0);
        end
        r.st.pending_byte      = b;
        r.st.pending_valid     = 1'b1;
        r.st.pending_is_header = hdr;
        if (hdr || (b != 8'h00))
        begin
            r.st.payload_zero_run = 2'd0;
        end
        else if (r.st.payload_zero_run < MAX_HELD)
        begin
            r.st.payload_zero_run = r.st.payload_zero_run + 2'd1;
        end
        return r;
    endfunction

    function automatic work_t close_unit(work_t w);
        work_t r;
        r = w;
        if (r.st.pending_valid)
        begin
            r = put_result(r, r.st.pending_byte, r.st.pending_is_header, 1'b1);
        end
        r.st.pending_valid     = 1'b0;
        r.st.pending_is_header = 1'b0;
        return r;
    endfunction

    function automatic work_t release_zeros(work_t w);
        work_t r;
        r = w;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < w.st.held_zero_count)
            begin
                r = send_payload(r, 8'h00, 1'b0);
            end
        end
        r.st.held_zero_count = 2'd0;
        return r;
    endfunction

    function automatic work_t take_byte(work_t w, logic [7:0] x, logic en);
        work_t r;
        r = w;
        if (r.st.inside_nal && r.st.next_is_header)
        begin
            r.st.next_is_header  = 1'b0;
            r.st.held_zero_count = 2'd0;
            r = send_payload(r, x, 1'b1);
        end
        else if (x == 8'h00)
        begin
            if (r.st.held_zero_count < MAX_HELD)
            begin
                r.st.held_zero_count = r.st.held_zero_count + 2'd1;
            end
            else if (r.st.inside_nal)
            begin
                r = send_payload(r, 8'h00, 1'b0);
            end
        end
        else if ((x == START_BYTE) && (r.st.held_zero_count >= 2'd2))
        begin
            r = close_unit(r);
            r.st.held_zero_count  = 2'd0;
            r.st.payload_zero_run = 2'd0;
            r.st.inside_nal       = 1'b1;
            r.st.next_is_header   = 1'b1;
        end
        else if (!r.st.inside_nal)
        begin
            r.st.held_zero_count = 2'd0;
        end
        else if ((x == EPB_BYTE) && en &&
                 (({1'b0, r.st.held_zero_count} + {1'b0, r.st.payload_zero_run}) >= 3'd2))
        begin
            r = release_zeros(r);
            r.st.payload_zero_run = 2'd0;
        end
        else
        begin
            r = release_zeros(r);
            r = send_payload(r, x, 1'b0);
        end
        return r;
    endfunction

    function automatic work_t step_byte(fe_state_t s, logic [7:0] x, logic fin, logic en);
        work_t r;
        r     = '0;
        r.st  = s;
        if (fin)
        begin
            // annex b: a unit ends at 00 00 00, trailing zeros are dropped
            if (s.inside_nal && !s.next_is_header &&
                ((x == 8'h00) || ((s.held_zero_count == MAX_HELD) && (x != START_BYTE))))
            begin
                r = close_unit(r);
            end
            else
            begin
                r = take_byte(r, x, en);
                r.st.held_zero_count = 2'd0;
                r = close_unit(r);
            end
            r.st = '0;
        end
        else
        begin
            r = take_byte(r, x, en);
        end
        return r;
    endfunction

endpackage

[src/nalepb_front.sv]
// front end: takes stream bytes, tracks start codes and builds result bundles
`timescale 1ns / 1ps

module nalepb_front
    import nalepb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output bundle_t    q_bundle
);

    fe_state_t st_reg;
    fe_state_t st_next;
    logic      epb_en_reg;
    logic      epb_en_next;
    work_t     work;
    logic      accept;

    assign accept = push && !q_stat.full;

    always_comb
    begin
        work = step_byte(st_reg, data_byte, stream_end, epb_en_reg);
    end

    assign st_next     = accept ? work.st : st_reg;
    assign epb_en_next = cfg_valid ? cfg_data : epb_en_reg;

    // bytes that cause no result never reach the queue
    assign q_push   = accept && (work.bun.cnt != 3'd0);
    assign q_bundle = work.bun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= '0;
            epb_en_reg <= 1'b1;
        end
        else
        begin
            st_reg     <= st_next;
            epb_en_reg <= epb_en_next;
        end
    end

endmodule

[src/nalepb_queue.sv]
// two-entry bundle queue between front and back
`timescale 1ns / 1ps

module nalepb_queue
    import nalepb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    input  logic    rd_en,
    output bundle_t rd_data,
    output q_stat_t stat
);

    bundle_t    mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.avail = (cnt_reg != 2'd0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && stat.avail;
    assign rd_data    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[src/nalepb_back.sv]
// back end: hands out the results of each bundle one per request
`timescale 1ns / 1ps

module nalepb_back
    import nalepb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_stat_t    q_stat,
    input  bundle_t    q_data,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       nal_first,
    output logic [4:0] nal_kind,
    output logic       nal_last
);

    bundle_t    cur_reg;
    bundle_t    cur_next;
    logic       cur_valid_reg;
    logic       cur_valid_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       taken;
    logic       at_end;
    res_t       res;

    assign empty  = !cur_valid_reg;
    assign taken  = pop && cur_valid_reg;
    assign at_end = ({1'b0, idx_reg} == (cur_reg.cnt - 3'd1));
    // refill on the same edge the last result of a bundle leaves
    assign q_pop  = q_stat.avail && (!cur_valid_reg || (taken && at_end));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (taken)
        begin
            if (at_end)
            begin
                cur_valid_next = 1'b0;
                idx_next       = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    assign res       = cur_reg.res[idx_reg];
    assign out_byte  = res.value;
    assign nal_first = res.hdr;
    assign nal_kind  = res.hdr ? res.value[4:0] : 5'd0;
    assign nal_last  = res.last;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

endmodule

[src/nal_start_code_epb_stripper_unit.sv]
// top level: annex b start code and emulation prevention byte stripper
//
// channel   direction  handshake            payload
// input     in         push / full          data_byte, stream_end
// result    out        empty / pop          out_byte, nal_first, nal_kind, nal_last
// config    in         cfg_valid/cfg_ready  cfg_data (epb removal enable)
//
// one byte is taken every cycle while the bundle queue has room; each byte is
// classified combinationally and gives 0 to 4 results.
// results leave at one per cycle while pop is held and bundles are waiting;
// the two-entry queue absorbs short bursts.
// reset clears all stream state and sets epb removal on; cfg is always ready.
// a result waits on the ports until popped, input keeps flowing until full.
`timescale 1ns / 1ps

module nal_start_code_epb_stripper_unit
    import nalepb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       stream_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       nal_first,
    output logic [4:0] nal_kind,
    output logic       nal_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    q_stat_t q_stat;
    logic    q_push;
    logic    q_pop;
    bundle_t q_wr_data;
    bundle_t q_rd_data;

    assign full      = q_stat.full;
    assign cfg_ready = 1'b1;

    nalepb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .data_byte  (data_byte),
        .stream_end (stream_end),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_bundle   (q_wr_data)
    );

    nalepb_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    nalepb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .out_byte  (out_byte),
        .nal_first (nal_first),
        .nal_kind  (nal_kind),
        .nal_last  (nal_last)
    );

    a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("bundle written into a full queue");

    a_empty_bundle : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (u_back.cur_reg.cnt != 3'd0) && (u_back.cur_reg.cnt <= MAX_RESULTS))
        else $error("bundle with bad result count loaded");

    a_refill : assert property (@(posedge clk) disable iff (!rst_n)
        (empty && q_stat.avail) |=> !empty)
        else $error("queued bundle not moved to output");

    a_kind_only_on_header : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !nal_first) |-> (nal_kind == 5'd0))
        else $error("nal kind shown on a non-header byte");

endmodule
